// ===== hw/rtl/fesp_pkg.sv =====
// Package: word types, command type, and flash sector layout for the erase planner.
package fesp_pkg;

    localparam logic [31:0] APP_BASE  = 32'h0800_8000;
    localparam logic [31:0] FLASH_TOP = 32'h0810_0000;

    localparam int unsigned SLOT_COUNT  = 10;
    localparam logic [3:0]  SECTOR_BASE = 4'd2;
    localparam logic [3:0]  SECTOR_NONE = 4'd0;

    // End boundary (exclusive) of sectors 2..11, indexed by sector - 2.
    localparam logic [31:0] SECTOR_LIMIT [SLOT_COUNT] = '{
        32'h0800_C000, 32'h0801_0000, 32'h0802_0000, 32'h0804_0000, 32'h0806_0000,
        32'h0808_0000, 32'h080A_0000, 32'h080C_0000, 32'h080E_0000, 32'h0810_0000
    };

    typedef struct packed {
        logic [31:0] start_address;
        logic [31:0] byte_length;
    } t_req;

    typedef struct packed {
        logic [3:0] sector_number;
        logic       range_error;
        logic       last_of_run;
    } t_res;

    // Classified request handed from front to back.
    typedef struct packed {
        logic       err;
        logic [3:0] first_sector;
        logic [3:0] last_sector;
    } t_cmd;

    // Sector number holding addr; addr is known to lie inside the application area.
    function automatic logic [3:0] sector_of(input logic [31:0] addr);
        logic [3:0] sec;
        sec = SECTOR_BASE + 4'(SLOT_COUNT - 1);
        for (int i = SLOT_COUNT - 2; i >= 0; i--) begin
            if (addr < SECTOR_LIMIT[i]) begin
                sec = SECTOR_BASE + 4'(i);
            end
        end
        return sec;
    endfunction

endpackage

// ===== hw/rtl/fesp_front.sv =====
// Front end: accept a request word, range-check it, and turn it into a sector span.
module fesp_front
    import fesp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_push,
    input  logic i_full,
    output t_cmd o_cmd
);

    logic        r_valid;
    t_req        r_req;
    logic        n_valid;
    logic        bad;
    logic [31:0] room;
    logic [31:0] last_byte;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;

    always_comb begin
        room      = FLASH_TOP - r_req.start_address;
        last_byte = r_req.start_address + (r_req.byte_length - 32'd1);
        bad       = (r_req.byte_length == 32'd0) || (r_req.start_address < APP_BASE) ||
                    (r_req.start_address >= FLASH_TOP) || (r_req.byte_length > room);
        o_cmd.err          = bad;
        o_cmd.first_sector = sector_of(r_req.start_address);
        o_cmd.last_sector  = sector_of(last_byte);
    end

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

// ===== hw/rtl/fesp_queue.sv =====
// Short command queue between front and back.
module fesp_queue
    import fesp_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_nempty,
    output t_cmd o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_cmd    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/fesp_back.sv =====
// Back end: walk a sector span and drive result words through an output register.
module fesp_back
    import fesp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_nempty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic       r_busy;
    logic       r_err;
    logic [3:0] r_cur;
    logic [3:0] r_last;
    logic       r_out_valid;
    t_res       r_out;
    logic       can_load;
    logic       emit;
    logic       final_word;

    assign can_load   = !r_out_valid || i_ready;
    assign emit       = r_busy && can_load;
    assign o_pop      = !r_busy && i_nempty;
    assign final_word = r_err || (r_cur == r_last);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && final_word) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_err  <= i_cmd.err;
            r_cur  <= i_cmd.first_sector;
            r_last <= i_cmd.last_sector;
        end else if (emit) begin
            r_cur <= r_cur + 4'd1;
        end
        if (emit) begin
            r_out.sector_number <= r_err ? SECTOR_NONE : r_cur;
            r_out.range_error   <= r_err;
            r_out.last_of_run   <= final_word;
        end
    end

endmodule

// ===== hw/rtl/flash_erase_sector_planner.sv =====
// Top level: flash erase sector planner, front end, command queue and back end.
//
//   channel   dir   handshake            word
//   request   in    i_valid / o_ready    i_req : t_req (start_address, byte_length)
//   result    out   o_valid / i_ready    o_res : t_res (sector_number, range_error,
//                                                      last_of_run)
//
// A request that touches n sectors gives n result words at one per cycle while i_ready
// is high; a rejected request gives one word. The back end loads each command from the
// queue before it walks it and takes no new command until it has emitted the last word
// of the current one; the first word passes queue write, back-end load and output register.
// Reset (synchronous, active low) empties the input register, queue and output
// register. Either side may stall on its own: the queue lets the front keep taking
// requests while the back end waits on i_ready.
module flash_erase_sector_planner
    import fesp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic push;
    logic pop;
    logic full;
    logic nempty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // Classify the request: range check, first and last sector.
    fesp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_push  (push),
        .i_full  (full),
        .o_cmd   (front_cmd)
    );

    // Hold classified commands until the back end is free.
    fesp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_cmd    (queue_cmd)
    );

    // Advance through the span, one sector word per cycle while the output is not stalled.
    fesp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nempty (nempty),
        .i_cmd    (queue_cmd),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (o_res)
    );

    // Error words carry no sector and always close their request.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.range_error |->
            o_res.sector_number == SECTOR_NONE && o_res.last_of_run)
        else $error("error word malformed");

    // Normal words name a sector from 2 to 11.
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.range_error |->
            o_res.sector_number >= SECTOR_BASE && o_res.sector_number <= 4'd11)
        else $error("sector out of range");

    // Within a run, the next word follows at once with the next sector.
    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_res.last_of_run |=>
            o_valid && !o_res.range_error &&
            o_res.sector_number == $past(o_res.sector_number) + 4'd1)
        else $error("sector walk broken");

endmodule

// ===== dv/tb_flash_erase_sector_planner.sv =====
// Testbench for the flash erase sector planner: directed and random requests, self-checked.
`timescale 1ns / 100ps

module tb_flash_erase_sector_planner
    import fesp_pkg::*;
();

    // Generous cycle budget: ~110 requests, each up to ten words, each word
    // possibly waiting out a long receiver stall, plus sender gaps and the hold.
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned RANDOM_ITEMS  = 80;
    localparam int unsigned SETTLE_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_req i_req   = '0;
    logic o_ready;
    logic o_valid;
    t_res o_res;

    // Expected result words, oldest first.
    t_res expected_sectors[$];

    // Run statistics and failure bookkeeping.
    int unsigned mismatch_count   = 0;
    int unsigned request_count    = 0;
    int unsigned rejected_count   = 0;
    int unsigned word_count       = 0;
    int unsigned longest_in_stall = 0;
    int unsigned cycle_count      = 0;

    // Stimulus shaping, set by the test tasks.
    bit          tx_gaps_on   = 1'b1;
    bit          rx_gaps_on   = 1'b1;
    bit          tx_live      = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_stall     = 0;

    flash_erase_sector_planner DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_sectors.size());
            $display("tb_flash_erase_sector_planner: FAIL");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Plan the erase for one request and queue the words the block must emit.
    // A rejected request yields one error word; otherwise walk sector by
    // sector, jumping to each sector's end boundary, until the last byte.
    function automatic void plan_erase(input t_req req);
        logic [31:0] addr;
        logic [31:0] last_addr;
        logic [31:0] bound;
        int unsigned slot;
        t_res        word;
        request_count++;
        if (req.byte_length == 32'd0 || req.start_address < APP_BASE ||
            req.start_address >= FLASH_TOP ||
            req.byte_length > (FLASH_TOP - req.start_address)) begin
            rejected_count++;
            word = '{sector_number: SECTOR_NONE, range_error: 1'b1, last_of_run: 1'b1};
            expected_sectors.push_back(word);
            return;
        end
        addr      = req.start_address;
        last_addr = req.start_address + (req.byte_length - 32'd1);
        while (addr <= last_addr) begin
            slot = 0;
            while (slot < SLOT_COUNT - 1 && addr >= SECTOR_LIMIT[slot]) begin
                slot++;
            end
            bound                = SECTOR_LIMIT[slot];
            word.sector_number   = SECTOR_BASE + 4'(slot);
            word.range_error     = 1'b0;
            word.last_of_run     = (bound > last_addr);
            expected_sectors.push_back(word);
            addr = bound;
        end
    endfunction

    // Random request: mostly well-formed ranges of varied size and alignment,
    // the rest noise and near-miss rejects.
    function automatic t_req random_request();
        t_req        req;
        logic [31:0] room;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            if ($urandom_range(0, 4) == 0) begin
                req.start_address = ($urandom_range(0, 9) == 0) ? APP_BASE :
                                    SECTOR_LIMIT[$urandom_range(0, SLOT_COUNT - 2)];
            end else begin
                req.start_address = $urandom_range(APP_BASE, FLASH_TOP - 1);
            end
            room = FLASH_TOP - req.start_address;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                req.byte_length = $urandom_range(1, (room > 32'h100) ? 32'h100 : room);
            end else if (pick < 70) begin
                req.byte_length = $urandom_range(1, room);
            end else if (pick < 85) begin
                req.byte_length = room;
            end else begin
                req.byte_length = room - $urandom_range(0, (room > 32'd4) ? 3 : room - 1);
            end
        end else if (pick < 88) begin
            req.start_address = $urandom;
            req.byte_length   = $urandom;
        end else if (pick < 92) begin
            req.start_address = $urandom_range(APP_BASE, FLASH_TOP - 1);
            req.byte_length   = '0;
        end else if (pick < 96) begin
            req.start_address = $urandom_range(APP_BASE, FLASH_TOP - 1);
            req.byte_length   = (FLASH_TOP - req.start_address) + $urandom_range(1, 4096);
        end else begin
            req.start_address = APP_BASE - $urandom_range(1, 32'h8000);
            req.byte_length   = $urandom_range(1, 32'h10000);
        end
        return req;
    endfunction

    // Offer one word on the request channel and hold it until accepted.
    // Valid is left high on return; a gap in the next send, or the drain, drops it.
    task automatic send_request(input t_req req);
        int unsigned gap;
        int unsigned waited;
        gap    = tx_gaps_on ? gap_len() : 0;
        waited = 0;
        if (gap > 0) begin
            if (tx_live) begin
                i_valid <= 1'b0;
                tx_live = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        tx_live = 1'b1;
        do begin
            @(posedge i_clk);
            if (!o_ready) begin
                waited++;
            end
        end while (!o_ready);
        if (waited > longest_in_stall) begin
            longest_in_stall = waited;
        end
        plan_erase(req);
    endtask

    // Drop valid and pause until every expected word has come back.
    task automatic drain_results();
        if (tx_live) begin
            i_valid <= 1'b0;
            tx_live = 1'b0;
        end
        do begin
            @(posedge i_clk);
        end while (expected_sectors.size() != 0);
    endtask

    // Result channel: compare each accepted word with the oldest expectation,
    // then pick ready for the next cycle (hold-off, random stall or open).
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            word_count++;
            if (expected_sectors.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected word: sector %0d err %0b last %0b",
                             o_res.sector_number, o_res.range_error, o_res.last_of_run);
                end
            end else begin
                want = expected_sectors.pop_front();
                if (o_res.sector_number !== want.sector_number ||
                    o_res.range_error !== want.range_error ||
                    o_res.last_of_run !== want.last_of_run) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected sector %0d err %0b last %0b, got %0d %0b %0b",
                                 want.sector_number, want.range_error, want.last_of_run,
                                 o_res.sector_number, o_res.range_error, o_res.last_of_run);
                    end
                end
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                rx_stall = gap_len();
            end
        end
    end

    // Every way a request can fail the range check.
    task automatic test_range_errors();
        send_request('{start_address: APP_BASE,          byte_length: 32'd0});
        send_request('{start_address: 32'd0,             byte_length: 32'd1});
        send_request('{start_address: APP_BASE - 32'd1,  byte_length: 32'd1});
        send_request('{start_address: FLASH_TOP,         byte_length: 32'd1});
        send_request('{start_address: 32'hFFFF_FFFF,     byte_length: 32'hFFFF_FFFF});
        send_request('{start_address: FLASH_TOP - 32'd1, byte_length: 32'd2});
        send_request('{start_address: APP_BASE,          byte_length: 32'hFFFF_FFFF});
        send_request('{start_address: 32'h0800_0000,     byte_length: 32'h0010_0000});
        drain_results();
    endtask

    // Valid walks: single bytes at both ends, the whole area, boundary crossings.
    task automatic test_sector_walks();
        send_request('{start_address: APP_BASE,          byte_length: 32'd1});
        send_request('{start_address: FLASH_TOP - 32'd1, byte_length: 32'd1});
        send_request('{start_address: APP_BASE,          byte_length: FLASH_TOP - APP_BASE});
        send_request('{start_address: 32'h0800_BFFF,     byte_length: 32'd2});
        send_request('{start_address: 32'h0800_C000,     byte_length: 32'h0000_4000});
        send_request('{start_address: 32'h0801_FFFF,     byte_length: 32'd1});
        send_request('{start_address: 32'h0802_0000,     byte_length: 32'h0004_0001});
        send_request('{start_address: 32'h080E_0000,     byte_length: 32'h0002_0000});
        send_request('{start_address: 32'h080F_0000,     byte_length: 32'h0001_0000});
        drain_results();
    endtask

    // Hold the receiver off while the sender keeps pushing back to back, so
    // the queue fills and the request channel has to stall.
    task automatic test_back_pressure();
        tx_gaps_on   = 1'b0;
        rx_hold_left = 150;
        repeat (12) begin
            send_request(random_request());
        end
        drain_results();
        tx_gaps_on = 1'b1;
    endtask

    // Bulk random traffic in stretches: idling on, idling off, one side only;
    // drain fully between stretches.
    task automatic test_random_requests();
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0) begin
                tx_gaps_on = (n / 20) % 2 == 0;
                rx_gaps_on = (n / 20) != 1;
            end
            send_request(random_request());
            if (n % 20 == 19) begin
                drain_results();
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_errors();
        test_sector_walks();
        test_back_pressure();
        test_random_requests();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatch_count += expected_sectors.size();

        $display("covered %0d requests (%0d rejected), %0d result words checked",
                 request_count, rejected_count, word_count);
        $display("longest request stall %0d cycles, %0d mismatches",
                 longest_in_stall, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_flash_erase_sector_planner: PASS");
        end else begin
            $display("tb_flash_erase_sector_planner: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fesp_pkg.sv
hw/rtl/fesp_front.sv
hw/rtl/fesp_queue.sv
hw/rtl/fesp_back.sv
hw/rtl/flash_erase_sector_planner.sv
dv/tb_flash_erase_sector_planner.sv
